// File: design/din_pkg.sv
`default_nettype none

package din_pkg;

  localparam int unsigned NUM_LANES = 4;

  // pulse and learning window lengths
  localparam logic [7:0]  PULSE_LEN    = 8'd128;
  localparam logic [10:0] LEARN_WINDOW = 11'd1024;
  // LEARN_WINDOW is a power of two: the learning divide is this shift
  localparam int unsigned LEARN_SHIFT  = 10;

  localparam logic [15:0] GAIN_RESET  = 16'd1000;
  localparam logic [14:0] LIMIT_RESET = 15'd32767;

  localparam logic [15:0] WEIGHT_INIT [NUM_LANES] = '{16'd15000, 16'd8000, 16'd8000, 16'd15000};

  typedef enum logic [0:0] {
    CFG_LEARN_GAIN   = 1'b0,
    CFG_WEIGHT_LIMIT = 1'b1
  } cfg_reg_e;

  // per-lane tick request
  typedef struct packed {
    logic accept;
    logic excite;
    logic inhibit;
    logic decay;
    logic learn;
  } tick_t;

  // per-lane view of current state, for the merge stage
  typedef struct packed {
    logic        active;
    logic [15:0] contrib;
  } lane_out_t;

endpackage

`default_nettype wire

// File: design/din_lane.sv
`default_nettype none

module din_lane #(
  parameter logic [15:0] WeightInit = 16'd8000
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire din_pkg::tick_t    tick_i,
  input  wire logic [15:0]       gain_i,
  input  wire logic [14:0]       limit_i,
  output din_pkg::lane_out_t     lane_o
);
  import din_pkg::*;

  logic [15:0] weight_q, weight_d;
  logic [15:0] resid_q, resid_d;
  logic        act_q, act_d;
  logic        inh_q, inh_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [10:0] since_q, since_d;

  logic               flag, act_mid, inh_mid, ended;
  logic [7:0]         cnt_mid, cnt_inc;
  logic [10:0]        since_mid, since_new, age;
  logic [15:0]        res_mid, res_dec, w_learn, w_signed;
  logic signed [21:0] r_ext, r63, r_bias, r_shift;
  logic [26:0]        prod;
  logic [16:0]        inc;
  logic [17:0]        w_sum;

  always_comb begin
    // pulse flags: inhibitory wins
    flag    = tick_i.excite | tick_i.inhibit;
    inh_mid = flag ? tick_i.inhibit : inh_q;
    act_mid = flag | act_q;
    cnt_mid = flag ? 8'd0 : cnt_q;

    since_mid = (act_mid && (cnt_mid == 8'd0)) ? 11'd0 : since_q;
    cnt_inc   = cnt_mid + 8'd1;
    ended     = act_mid && (cnt_inc >= PULSE_LEN);

    act_d = act_mid && !ended;
    inh_d = inh_mid;
    cnt_d = act_mid ? (ended ? 8'd0 : cnt_inc) : cnt_mid;

    res_mid = resid_q;
    if (ended) begin
      res_mid = inh_mid ? (resid_q - weight_q) : (resid_q + weight_q);
    end

    since_new = (since_mid < LEARN_WINDOW) ? (since_mid + 11'd1) : since_mid;

    // residual * 63 / 64, truncating toward zero
    r_ext   = {{6{res_mid[15]}}, res_mid};
    r63     = (r_ext <<< 6) - r_ext;
    r_bias  = r63 + (r63[21] ? 22'sd63 : 22'sd0);
    r_shift = r_bias >>> 6;
    res_dec = r_shift[15:0];
    resid_d = tick_i.decay ? res_dec : res_mid;

    // Hebbian gain, clamped to the limit
    age     = LEARN_WINDOW - since_new;
    prod    = {16'd0, age} * {11'd0, gain_i};
    inc     = prod[LEARN_SHIFT +: 17];
    w_sum   = {2'b00, weight_q} + {1'b0, inc};
    w_learn = (w_sum > {3'b000, limit_i}) ? {1'b0, limit_i} : w_sum[15:0];

    weight_d = weight_q;
    since_d  = since_new;
    if (tick_i.learn) begin
      if (since_new < LEARN_WINDOW) begin
        weight_d = w_learn;
      end
      since_d = LEARN_WINDOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WeightInit;
      resid_q  <= '0;
      act_q    <= 1'b0;
      inh_q    <= 1'b0;
      cnt_q    <= PULSE_LEN;
      since_q  <= LEARN_WINDOW;
    end else if (tick_i.accept) begin
      weight_q <= weight_d;
      resid_q  <= resid_d;
      act_q    <= act_d;
      inh_q    <= inh_d;
      cnt_q    <= cnt_d;
      since_q  <= since_d;
    end
  end

  always_comb begin
    w_signed = act_q ? (inh_q ? (16'd0 - weight_q) : weight_q) : 16'd0;
    lane_o.active  = act_q;
    lane_o.contrib = resid_q + w_signed;
  end

endmodule

`default_nettype wire

// File: design/din_merge.sv
`default_nettype none

module din_merge (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire din_pkg::lane_out_t   lane_i [din_pkg::NUM_LANES],
  input  wire logic                 accept_i,
  input  wire logic                 out_ready_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output logic [15:0]               potential_o,
  output logic [din_pkg::NUM_LANES-1:0] mask_o
);
  import din_pkg::*;

  // pend_q: lane state holds a word whose result is not yet sampled
  logic pend_q, pend_d;
  logic oval_q, oval_d;
  logic out_move, load;
  logic [15:0] pot_q, pot_sum;
  logic [NUM_LANES-1:0] mask_q, mask_sum;

  always_comb begin
    pot_sum = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      pot_sum     = pot_sum + lane_i[l].contrib;
      mask_sum[l] = lane_i[l].active;
    end
  end

  always_comb begin
    out_move   = !oval_q || out_ready_i;
    load       = pend_q && out_move;
    in_ready_o = !pend_q || out_move;
    pend_d     = accept_i ? 1'b1 : (load ? 1'b0 : pend_q);
    oval_d     = load ? 1'b1 : (out_ready_i ? 1'b0 : oval_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pot_q  <= pot_sum;
      mask_q <= mask_sum;
    end
  end

  assign out_valid_o = oval_q;
  assign potential_o = pot_q;
  assign mask_o      = mask_q;

endmodule

`default_nettype wire

// File: design/dendrite_integrate_neuron.sv
// Four-dendrite integrating neuron, one tick per input word.
// Throughput: one word per cycle while the result stream is not stalled; the
// four dendrite lanes register their state on an accepted word (per-lane 11x16
// learning multiply), then the merge stage registers the summed result word.
// A stalled result word holds off input once a further word waits in the lanes.
// Reset (rst_ni, async, active low): weights 15000/8000/8000/15000, residuals
// zero, dendrites off, learn_gain 1000, weight_limit 32767, output empty.
`default_nettype none

module dendrite_integrate_neuron (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  // [3:0] pulse_excite, [7:4] pulse_inhibit, [8] do_decay, [9] do_learn, [15:10] zero
  input  wire logic [15:0] s_tdata_i,
  // result stream
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  // [15:0] potential (signed), [19:16] active_mask, [23:20] zero
  output logic [23:0]      m_tdata_o,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);
  import din_pkg::*;

  logic [15:0] gain_q;
  logic [14:0] limit_q;

  logic                 accept;
  logic [3:0]           excite, inhibit;
  logic                 do_decay, do_learn;
  tick_t                tick [NUM_LANES];
  lane_out_t            lane_out [NUM_LANES];
  logic [15:0]          potential;
  logic [NUM_LANES-1:0] mask;

  // configuration registers; the user must write only while idle (not enforced here)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_LEARN_GAIN:   gain_q  <= cfg_wdata_i;
        CFG_WEIGHT_LIMIT: limit_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // unpack the input word
  assign accept   = s_tvalid_i && s_tready_o;
  assign excite   = s_tdata_i[3:0];
  assign inhibit  = s_tdata_i[7:4];
  assign do_decay = s_tdata_i[8];
  assign do_learn = s_tdata_i[9];

  // one lane per dendrite; state only advances on an accepted word
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    assign tick[l] = '{accept:  accept,
                       excite:  excite[l],
                       inhibit: inhibit[l],
                       decay:   do_decay,
                       learn:   do_learn};

    din_lane #(
      .WeightInit(WEIGHT_INIT[l])
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tick_i (tick[l]),
      .gain_i (gain_q),
      .limit_i(limit_q),
      .lane_o (lane_out[l])
    );
  end

  // merge stage: sums lane contributions into the output register
  din_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .lane_i     (lane_out),
    .accept_i   (accept),
    .out_ready_i(m_tready_i),
    .in_ready_o (s_tready_o),
    .out_valid_o(m_tvalid_o),
    .potential_o(potential),
    .mask_o     (mask)
  );

  assign m_tdata_o = {4'd0, mask, potential};

endmodule

`default_nettype wire
